### sv/ths_pkg.sv
// ths_pkg: shared constants, codes and control structs of the terrain horizon scan
// depends on nothing; used by ths_ctrl, ths_dp and terrain_horizon_scan
`timescale 1ns / 1ps
`default_nettype none
package ths_pkg;

   localparam int MAX_POINTS_DEF  = 1024;
   localparam int ANGLE_FRAC_DEF  = 24;

   localparam int HEIGHT_W   = 18;
   localparam int DIST_W     = 30;
   localparam int ANG_OUT_W  = 32;
   localparam int ANT_W      = 16;
   localparam int SPACING_W  = 20;
   localparam int RADIUS_W   = 26;
   localparam int DIFF_W     = 20;
   localparam int DEN_W      = 30;
   localparam int REM_W      = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 30;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TX_ANT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RX_ANT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPACING = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PATH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS  = 3'd4;

   // register reset values
   localparam logic [ANT_W-1:0]     TX_ANT_RST  = 16'd80;
   localparam logic [ANT_W-1:0]     RX_ANT_RST  = 16'd80;
   localparam logic [SPACING_W-1:0] SPACING_RST = 20'd800;
   localparam logic [DIST_W-1:0]    PATH_RST    = 30'd818400;
   localparam logic [RADIUS_W-1:0]  RADIUS_RST  = 26'd8495000;

   // divider operations
   typedef enum logic [2:0] {
      OP_LOS_C,
      OP_LOS_TX,
      OP_LOS_RX,
      OP_TX_R,
      OP_TX_C,
      OP_RX_R,
      OP_RX_C
   } op_type;

   typedef struct packed {
      logic   load;
      logic   div_start;
      op_type op;
      logic   apply;
      logic   scan_init;
      logic   advance;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic div_busy;
      logic k_end;
      logic tx_ok;
      logic rx_ok;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

### sv/ths_ctrl.sv
// ths_ctrl: sequencer of profile load, divider operations and result hand-off
// depends on ths_pkg
`timescale 1ns / 1ps
`default_nettype none
module ths_ctrl
   import ths_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  wire        req_last_point,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_CHECK,
      ST_READ,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cmd           = '0;
      cmd.op        = op_ff;
      req_ready     = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid && req_last_point) begin
               op_in    = OP_LOS_C;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.apply = 1'b1;
               case (op_ff)
                  OP_LOS_C: begin
                     op_in    = OP_LOS_TX;
                     state_in = ST_DIV_GO;
                  end
                  OP_LOS_TX: begin
                     op_in    = OP_LOS_RX;
                     state_in = ST_DIV_GO;
                  end
                  OP_LOS_RX: begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_CHECK;
                  end
                  OP_TX_R: begin
                     op_in    = OP_TX_C;
                     state_in = ST_DIV_GO;
                  end
                  OP_TX_C: begin
                     if (status.rx_ok) begin
                        op_in    = OP_RX_R;
                        state_in = ST_DIV_GO;
                     end else begin
                        cmd.advance = 1'b1;
                        state_in    = ST_CHECK;
                     end
                  end
                  OP_RX_R: begin
                     op_in    = OP_RX_C;
                     state_in = ST_DIV_GO;
                  end
                  OP_RX_C: begin
                     cmd.advance = 1'b1;
                     state_in    = ST_CHECK;
                  end
                  default: state_in = ST_LOAD;
               endcase
            end
         end
         ST_CHECK: begin
            state_in = status.k_end ? ST_OUT : ST_READ;
         end
         ST_READ: begin
            if (status.tx_ok) begin
               op_in    = OP_TX_R;
               state_in = ST_DIV_GO;
            end else if (status.rx_ok) begin
               op_in    = OP_RX_R;
               state_in = ST_DIV_GO;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         op_ff    <= OP_LOS_C;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> !cmd.div_start)
      else $error("divider restarted while busy");

   a_scan_blocks_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_point |=> !req_ready)
      else $error("item taken during scan");

   a_apply_after_done: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> status.div_done && !status.div_busy)
      else $error("result applied before division finished");

endmodule
`default_nettype wire

### sv/ths_dp.sv
// ths_dp: configuration registers, profile store, serial divider, horizon trackers
// depends on ths_pkg; commanded by ths_ctrl
`timescale 1ns / 1ps
`default_nettype none
module ths_dp
   import ths_pkg::*;
#(
   parameter int MAX_POINTS      = MAX_POINTS_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_valid,
   input  wire [CSR_IDX_W-1:0]          csr_index,
   input  wire [CSR_DATA_W-1:0]         csr_data,
   input  wire signed [HEIGHT_W-1:0]    req_terrain_height,
   input  wire                          req_last_point,
   input  wire                          rsp_ready,
   output logic                         rsp_valid,
   output logic signed [ANG_OUT_W-1:0]  rsp_tx_horizon_angle,
   output logic [DIST_W-1:0]            rsp_tx_horizon_distance,
   output logic signed [ANG_OUT_W-1:0]  rsp_rx_horizon_angle,
   output logic [DIST_W-1:0]            rsp_rx_horizon_distance,
   output logic                         rsp_profile_overflow,
   input  cmd_type                      cmd,
   output status_type                   status
);

   localparam int AWM  = $clog2(MAX_POINTS);
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int DIVW = DIST_W + ANGLE_FRAC_BITS;
   localparam int QW   = DIVW + 1;
   localparam int AW   = DIVW + 2;
   localparam int CNTW = $clog2(DIVW + 1);

   // configuration
   logic [ANT_W-1:0]     tx_ant_ff;
   logic [ANT_W-1:0]     rx_ant_ff;
   logic [SPACING_W-1:0] spacing_ff;
   logic [DIST_W-1:0]    path_ff;
   logic [RADIUS_W-1:0]  radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ant_ff  <= TX_ANT_RST;
         rx_ant_ff  <= RX_ANT_RST;
         spacing_ff <= SPACING_RST;
         path_ff    <= PATH_RST;
         radius_ff  <= RADIUS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TX_ANT:  tx_ant_ff  <= csr_data[ANT_W-1:0];
            REG_RX_ANT:  rx_ant_ff  <= csr_data[ANT_W-1:0];
            REG_SPACING: spacing_ff <= csr_data[SPACING_W-1:0];
            REG_PATH:    path_ff    <= csr_data[DIST_W-1:0];
            REG_RADIUS:  radius_ff  <= csr_data[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // profile store and load counters
   logic signed [HEIGHT_W-1:0] mem [MAX_POINTS];
   logic signed [HEIGHT_W-1:0] rd_ff;
   logic signed [HEIGHT_W-1:0] first_ff, last_ff;
   logic [CW-1:0]              pts_ff;
   logic                       ovf_ff;
   logic [CW-1:0]              k_ff;
   logic [DIST_W-1:0]          dt_ff;
   logic                       room;

   assign room = pts_ff < CW'(MAX_POINTS);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (room) begin
            mem[pts_ff[AWM-1:0]] <= req_terrain_height;
         end else if (req_last_point) begin
            mem[AWM'(MAX_POINTS - 1)] <= req_terrain_height;
         end
      end
      rd_ff <= mem[k_ff[AWM-1:0]];
   end

   logic [DIST_W:0] dt_sum;
   assign dt_sum = {1'b0, dt_ff} + (DIST_W+1)'(spacing_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.load) begin
         if (room) pts_ff <= pts_ff + 1'b1;
         else      ovf_ff <= 1'b1;
      end else if (cmd.out_load) begin
         pts_ff <= '0;
         ovf_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && pts_ff == '0) first_ff <= req_terrain_height;
      if (cmd.load) last_ff <= req_terrain_height;
      if (cmd.scan_init) begin
         k_ff  <= CW'(1);
         dt_ff <= DIST_W'(spacing_ff);
      end else if (cmd.advance) begin
         k_ff  <= k_ff + 1'b1;
         dt_ff <= (dt_sum > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX : dt_sum[DIST_W-1:0];
      end
   end

   // terminal heights and operand selection
   logic signed [DIFF_W-1:0] tx_r, rx_r, hk, sd;
   logic [DIST_W-1:0]        dr;
   logic [DEN_W-1:0]         den_sel, curve_den;
   logic [DIST_W-1:0]        num_mag;
   logic                     num_neg;

   assign tx_r      = DIFF_W'(first_ff) + $signed({4'b0, tx_ant_ff});
   assign rx_r      = DIFF_W'(last_ff) + $signed({4'b0, rx_ant_ff});
   assign hk        = DIFF_W'(rd_ff);
   assign dr        = path_ff - dt_ff;
   assign curve_den = {radius_ff, 4'b0};

   always_comb begin
      sd      = '0;
      den_sel = curve_den;
      num_mag = '0;
      num_neg = 1'b0;
      case (cmd.op)
         OP_LOS_C: num_mag = path_ff;
         OP_LOS_TX: begin sd = rx_r - tx_r; den_sel = path_ff; end
         OP_LOS_RX: begin sd = tx_r - rx_r; den_sel = path_ff; end
         OP_TX_R:   begin sd = hk - tx_r;   den_sel = dt_ff;   end
         OP_TX_C:   num_mag = dt_ff;
         OP_RX_R:   begin sd = hk - rx_r;   den_sel = dr;      end
         OP_RX_C:   num_mag = dr;
         default: ;
      endcase
      if (cmd.op == OP_LOS_TX || cmd.op == OP_LOS_RX ||
          cmd.op == OP_TX_R || cmd.op == OP_RX_R) begin
         num_neg = sd[DIFF_W-1];
         num_mag = DIST_W'(num_neg ? -sd : sd);
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [DIVW-1:0]  quo_ff;
   logic [REM_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNTW-1:0]  cnt_ff;
   logic             neg_ff, zero_ff, fin_ff, done_ff;
   logic signed [QW-1:0] res_ff;
   logic [REM_W-1:0] sh;
   logic [REM_W:0]   trial;

   assign sh    = {rem_ff[REM_W-2:0], quo_ff[DIVW-1]};
   assign trial = {1'b0, sh} - {2'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         fin_ff <= 1'b0;
         if (cmd.div_start) begin
            cnt_ff  <= CNTW'(DIVW);
            done_ff <= 1'b0;
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNTW'(1)) fin_ff <= 1'b1;
         end
         if (fin_ff) done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff  <= {num_mag, {ANGLE_FRAC_BITS{1'b0}}};
         rem_ff  <= '0;
         den_ff  <= den_sel;
         neg_ff  <= num_neg;
         zero_ff <= (den_sel == '0);
      end else if (cnt_ff != '0) begin
         rem_ff <= trial[REM_W] ? sh : trial[REM_W-1:0];
         quo_ff <= {quo_ff[DIVW-2:0], ~trial[REM_W]};
      end
      if (fin_ff) begin
         // floor for negative numerators
         if (zero_ff)     res_ff <= '0;
         else if (neg_ff) res_ff <= -($signed({1'b0, quo_ff}) + QW'(rem_ff != '0));
         else             res_ff <= $signed({1'b0, quo_ff});
      end
   end

   // horizon trackers
   logic signed [QW-1:0] c0_ff, ratio_ff;
   logic signed [AW-1:0] tx_ang_ff, rx_ang_ff, cand;
   logic [DIST_W-1:0]    tx_dist_ff, rx_dist_ff;
   logic signed [QW-1:0] base;

   assign base = (cmd.op == OP_TX_C || cmd.op == OP_RX_C) ? ratio_ff : res_ff;
   always_comb begin
      if (cmd.op == OP_TX_C || cmd.op == OP_RX_C)
         cand = AW'(base) - AW'(res_ff);
      else
         cand = AW'(base) - AW'(c0_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         case (cmd.op)
            OP_LOS_C: c0_ff <= res_ff;
            OP_LOS_TX: begin tx_ang_ff <= cand; tx_dist_ff <= path_ff; end
            OP_LOS_RX: begin rx_ang_ff <= cand; rx_dist_ff <= path_ff; end
            OP_TX_R, OP_RX_R: ratio_ff <= res_ff;
            OP_TX_C: begin
               if (cand > tx_ang_ff) begin
                  tx_ang_ff  <= cand;
                  tx_dist_ff <= dt_ff;
               end
            end
            OP_RX_C: begin
               if (cand > rx_ang_ff) begin
                  rx_ang_ff  <= cand;
                  rx_dist_ff <= dr;
               end
            end
            default: ;
         endcase
      end
   end

   function automatic logic [ANG_OUT_W-1:0] sat_angle(input logic [AW-1:0] a);
      logic [AW-ANG_OUT_W:0] hi;
      hi = a[AW-1:ANG_OUT_W-1];
      if ((&hi) || !(|hi)) return a[ANG_OUT_W-1:0];
      return a[AW-1] ? {1'b1, {(ANG_OUT_W-1){1'b0}}} : {1'b0, {(ANG_OUT_W-1){1'b1}}};
   endfunction

   // result register
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_tx_horizon_angle    <= sat_angle(tx_ang_ff);
         rsp_tx_horizon_distance <= tx_dist_ff;
         rsp_rx_horizon_angle    <= sat_angle(rx_ang_ff);
         rsp_rx_horizon_distance <= rx_dist_ff;
         rsp_profile_overflow    <= ovf_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.div_done = done_ff;
   assign status.div_busy = (cnt_ff != '0) || fin_ff;
   assign status.k_end    = ({1'b0, k_ff} + (CW+1)'(1)) >= {1'b0, pts_ff};
   assign status.tx_ok    = (dt_ff != '0);
   assign status.rx_ok    = (path_ff > dt_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

### sv/terrain_horizon_scan.sv
// terrain_horizon_scan: top level, controller and datapath of the horizon search
// depends on ths_pkg, ths_ctrl, ths_dp
// load: one item per cycle to the last item, then none until the result is loaded;
// the scan does the line-of-sight divisions, then any ratio and curvature divisions
// of each interior point on the single bit-serial divider shared by all angle terms
// reset: registers to defaults, point and divider counts cleared, store not cleared
`timescale 1ns / 1ps
`default_nettype none
module terrain_horizon_scan
   import ths_pkg::*;
#(
   parameter int MAX_POINTS      = MAX_POINTS_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   // profile point items
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire signed [HEIGHT_W-1:0]    req_terrain_height,
   input  wire                          req_last_point,
   // horizon result items
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [ANG_OUT_W-1:0]  rsp_tx_horizon_angle,
   output logic [DIST_W-1:0]            rsp_tx_horizon_distance,
   output logic signed [ANG_OUT_W-1:0]  rsp_rx_horizon_angle,
   output logic [DIST_W-1:0]            rsp_rx_horizon_distance,
   output logic                         rsp_profile_overflow,
   // register writes
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [CSR_IDX_W-1:0]          csr_index,
   input  wire [CSR_DATA_W-1:0]         csr_data
);

   cmd_type    cmd;
   status_type status;

   // registers always take a write
   assign csr_ready = 1'b1;

   // sequencer: load, line-of-sight start values, interior point scan, hand-off
   ths_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_point (req_last_point),
      .req_ready      (req_ready),
      .status         (status),
      .cmd            (cmd)
   );

   // store, divider, trackers and result register
   ths_dp #(
      .MAX_POINTS      (MAX_POINTS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .req_terrain_height      (req_terrain_height),
      .req_last_point          (req_last_point),
      .rsp_ready               (rsp_ready),
      .rsp_valid               (rsp_valid),
      .rsp_tx_horizon_angle    (rsp_tx_horizon_angle),
      .rsp_tx_horizon_distance (rsp_tx_horizon_distance),
      .rsp_rx_horizon_angle    (rsp_rx_horizon_angle),
      .rsp_rx_horizon_distance (rsp_rx_horizon_distance),
      .rsp_profile_overflow    (rsp_profile_overflow),
      .cmd                     (cmd),
      .status                  (status)
   );

   // a new result only goes out once the previous item has left
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   // loading and result hand-off never overlap
   a_load_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.out_load))
      else $error("load during hand-off");

   // a result follows only a scan, never a plain load
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("result without scan");

endmodule
`default_nettype wire

### tb/terrain_horizon_scan_tb.sv
// terrain_horizon_scan_tb: self-checking bench for the terrain horizon scan
// depends on ths_pkg and terrain_horizon_scan; profiles are streamed in and each
// result is checked against a bit-exact predictor held in a small scoreboard class
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
   logic signed [31:0] tx_angle;
   logic [29:0]        tx_dist;
   logic signed [31:0] rx_angle;
   logic [29:0]        rx_dist;
   logic               overflow;
} horizon_result_type;

class horizon_scoreboard;
   localparam int NPTS = ths_pkg::MAX_POINTS_DEF;
   localparam int FRAC = ths_pkg::ANGLE_FRAC_DEF;
   localparam longint unsigned DMAX = 64'd1073741823;

   longint unsigned tx_ant, rx_ant, spacing, path_len, radius;
   int              heights [NPTS];
   int unsigned     loaded;
   bit              overflowed;
   horizon_result_type pending_results [$];
   int              errors;

   function void reset_state();
      tx_ant     = ths_pkg::TX_ANT_RST;
      rx_ant     = ths_pkg::RX_ANT_RST;
      spacing    = ths_pkg::SPACING_RST;
      path_len   = ths_pkg::PATH_RST;
      radius     = ths_pkg::RADIUS_RST;
      loaded     = 0;
      overflowed = 0;
      errors     = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [29:0] data);
      case (idx)
         ths_pkg::REG_TX_ANT:  tx_ant   = data[15:0];
         ths_pkg::REG_RX_ANT:  rx_ant   = data[15:0];
         ths_pkg::REG_SPACING: spacing  = data[19:0];
         ths_pkg::REG_PATH:    path_len = data[29:0];
         ths_pkg::REG_RADIUS:  radius   = data[25:0];
         default: ;
      endcase
   endfunction

   // floor(num * 2^F / den), rounding toward minus infinity
   function longint slope_q(longint num, longint unsigned den);
      bit neg;
      longint unsigned mag, m, q;
      neg = num < 0;
      mag = neg ? longint'(-num) : longint'(num);
      m = mag << FRAC;
      q = m / den;
      if (neg) begin
         if (m % den != 0) q++;
         return -longint'(q);
      end
      return longint'(q);
   endfunction

   function longint drop_q(longint unsigned d);
      if (radius == 0) return 0;
      return longint'((d << FRAC) / (64'd16 * radius));
   endfunction

   function logic signed [31:0] clip_angle(longint a);
      if (a > 64'sd2147483647) return 32'sh7fffffff;
      if (a < -64'sd2147483648) return 32'sh80000000;
      return a[31:0];
   endfunction

   function void note_point(logic signed [17:0] h_in, logic last);
      int h, n;
      longint tx_ref, rx_ref, c0, tx_ang, rx_ang, hk, a;
      longint unsigned tx_d, rx_d, dt, dr;
      horizon_result_type r;
      h = h_in;
      if (loaded < NPTS) begin
         heights[loaded] = h;
         loaded++;
      end else begin
         overflowed = 1;
         if (last) heights[NPTS-1] = h;
      end
      if (!last) return;
      n = loaded;
      tx_ref = longint'(heights[0]) + longint'(tx_ant);
      rx_ref = longint'(heights[n-1]) + longint'(rx_ant);
      c0 = drop_q(path_len);
      if (path_len != 0) begin
         tx_ang = slope_q(rx_ref - tx_ref, path_len) - c0;
         rx_ang = slope_q(tx_ref - rx_ref, path_len) - c0;
      end else begin
         tx_ang = -c0;
         rx_ang = -c0;
      end
      tx_d = path_len;
      rx_d = path_len;
      for (int k = 1; k + 1 < n; k++) begin
         dt = longint'(k) * spacing;
         if (dt > DMAX) dt = DMAX;
         hk = heights[k];
         if (dt != 0) begin
            a = slope_q(hk - tx_ref, dt) - drop_q(dt);
            if (a > tx_ang) begin
               tx_ang = a;
               tx_d = dt;
            end
         end
         if (path_len > dt) begin
            dr = path_len - dt;
            a = slope_q(hk - rx_ref, dr) - drop_q(dr);
            if (a > rx_ang) begin
               rx_ang = a;
               rx_d = dr;
            end
         end
      end
      r.tx_angle = clip_angle(tx_ang);
      r.tx_dist  = tx_d[29:0];
      r.rx_angle = clip_angle(rx_ang);
      r.rx_dist  = rx_d[29:0];
      r.overflow = overflowed;
      pending_results.push_back(r);
      loaded = 0;
      overflowed = 0;
   endfunction

   function void check_result(horizon_result_type got);
      horizon_result_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result item, got tx %0d/%0d rx %0d/%0d ovf %0d", $time,
            got.tx_angle, got.tx_dist, got.rx_angle, got.rx_dist, got.overflow);
         errors++;
         return;
      end
      want = pending_results.pop_front();
      if (got.tx_angle !== want.tx_angle) begin
         $display("%0t: tx_horizon_angle expected %0d actual %0d", $time,
            want.tx_angle, got.tx_angle);
         errors++;
      end
      if (got.tx_dist !== want.tx_dist) begin
         $display("%0t: tx_horizon_distance expected %0d actual %0d", $time,
            want.tx_dist, got.tx_dist);
         errors++;
      end
      if (got.rx_angle !== want.rx_angle) begin
         $display("%0t: rx_horizon_angle expected %0d actual %0d", $time,
            want.rx_angle, got.rx_angle);
         errors++;
      end
      if (got.rx_dist !== want.rx_dist) begin
         $display("%0t: rx_horizon_distance expected %0d actual %0d", $time,
            want.rx_dist, got.rx_dist);
         errors++;
      end
      if (got.overflow !== want.overflow) begin
         $display("%0t: profile_overflow expected %0d actual %0d", $time,
            want.overflow, got.overflow);
         errors++;
      end
   endfunction
endclass

module terrain_horizon_scan_tb;
   import ths_pkg::*;

   // no-progress limit, set well above the length of a full 1024-point scan
   localparam int STALL_LIMIT = 1500000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_ready;
   logic signed [17:0]    req_terrain_height = '0;
   logic                  req_last_point = 0;
   logic                  rsp_valid;
   logic                  rsp_ready = 0;
   logic signed [31:0]    rsp_tx_horizon_angle;
   logic [DIST_W-1:0]     rsp_tx_horizon_distance;
   logic signed [31:0]    rsp_rx_horizon_angle;
   logic [DIST_W-1:0]     rsp_rx_horizon_distance;
   logic                  rsp_profile_overflow;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   horizon_scoreboard sb = new();
   int idle_cycles = 0;
   int burst_left = 0;
   int stall_phase = 0;
   int stall_mode = 0;

   terrain_horizon_scan dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_terrain_height(req_terrain_height), .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_tx_horizon_angle(rsp_tx_horizon_angle),
      .rsp_tx_horizon_distance(rsp_tx_horizon_distance),
      .rsp_rx_horizon_angle(rsp_rx_horizon_angle),
      .rsp_rx_horizon_distance(rsp_rx_horizon_distance),
      .rsp_profile_overflow(rsp_profile_overflow),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // monitor: every accepted item goes to the scoreboard, values as seen at the edge
   always @(posedge clock) begin
      horizon_result_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) sb.note_point(req_terrain_height, req_last_point);
         if (rsp_valid && rsp_ready) begin
            got.tx_angle = rsp_tx_horizon_angle;
            got.tx_dist  = rsp_tx_horizon_distance;
            got.rx_angle = rsp_rx_horizon_angle;
            got.rx_dist  = rsp_rx_horizon_distance;
            got.overflow = rsp_profile_overflow;
            sb.check_result(got);
         end
      end
   end

   // receiver back-pressure: one of four patterns, picked anew at random from time to time
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= (stall_phase % 8 == 0);
         default: rsp_ready <= (stall_phase % 23) > 11;
      endcase
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // one item; valid stays up afterward so back-to-back items keep it high
   task automatic send_point(int h, bit last);
      req_valid          <= 1'b1;
      req_terrain_height <= h[17:0];
      req_last_point     <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // bursts of random length with random gaps between them
   task automatic send_paced(int h, bit last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9));
      end
      burst_left--;
      send_point(h, last);
   endtask

   // wait until every expected result has arrived, then let the block settle
   task automatic drain();
      pause_sender(1);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_all(int unsigned ta, int unsigned ra, int unsigned sp,
                          int unsigned pl, int unsigned er);
      write_reg(REG_TX_ANT, CSR_DATA_W'(ta));
      write_reg(REG_RX_ANT, CSR_DATA_W'(ra));
      write_reg(REG_SPACING, CSR_DATA_W'(sp));
      write_reg(REG_PATH, CSR_DATA_W'(pl));
      write_reg(REG_RADIUS, CSR_DATA_W'(er));
   endtask

   function automatic int rand_height();
      case ($urandom_range(0, 7))
         0: return -32768;
         1: return 131071;
         2: return $urandom_range(0, 255) - 128;
         default: return int'($urandom_range(0, 163839)) - 32768;
      endcase
   endfunction

   function automatic int unsigned pick(int unsigned lo, int unsigned hi);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   initial begin
      int n, sent;
      sb.reset_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset configuration, extreme heights
      send_point(0, 0);
      send_point(131071, 0);
      send_point(-32768, 0);
      send_point(100, 0);
      send_point(0, 1);
      // single point profile: both terminals on one point
      send_point(-32768, 1);
      // two points: no interior points
      send_point(131071, 0);
      send_point(-32768, 1);
      drain();

      // tiny distances and radius: steep slopes saturate the angles
      set_all(65535, 0, 1, 1, 1);
      send_point(5, 0);
      send_point(131071, 0);
      send_point(-32768, 0);
      send_point(7, 1);
      drain();

      // long path, large spacing: all points lie within the path
      set_all(0, 65535, 1048575, 1073741823, 67108863);
      for (int i = 0; i < 6; i++) send_point(i == 2 ? 131071 : -32768 + i, i == 5);
      drain();

      // store full: extra points dropped, last point still taken as receiver
      set_all(80, 80, 800, 818400, 8495000);
      for (int i = 0; i < 1030; i++) send_point(rand_height(), i == 1029);
      drain();

      // random profiles, mostly short, configuration changed between some of them
      sent = 0;
      while (sent < 650) begin
         if ($urandom_range(0, 3) == 0) begin
            drain();
            set_all(pick(0, 65535), pick(0, 65535), pick(1, 1048575),
                    pick(1, 1073741823), pick(1, 67108863));
            if ($urandom_range(0, 1)) begin
               // keep distances in a realistic range
               write_reg(REG_SPACING, CSR_DATA_W'($urandom_range(100, 4000)));
               write_reg(REG_PATH, CSR_DATA_W'($urandom_range(1, 60000)));
               write_reg(REG_RADIUS, CSR_DATA_W'($urandom_range(1000000, 67108863)));
            end
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 14);
         for (int i = 0; i < n; i++) send_paced(rand_height(), i == n - 1);
         sent += n;
      end

      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
sv/ths_pkg.sv
sv/ths_ctrl.sv
sv/ths_dp.sv
sv/terrain_horizon_scan.sv
tb/terrain_horizon_scan_tb.sv
